// File: rtl/f2i_pkg.sv
`default_nettype none
package f2i_pkg;

	typedef struct packed {
		logic [2:0]  round_mode;
		logic [63:0] value_bits;
	} f2i_in_t;

	typedef struct packed {
		logic signed [31:0] int_result;
		logic               overflow;
	} f2i_out_t;

	localparam logic [2:0]  MODE_NEAREST = 3'd0;
	localparam logic [2:0]  MODE_FLOOR   = 3'd1;
	localparam logic [2:0]  MODE_CEIL    = 3'd2;
	localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
	localparam logic [10:0] EXP_UNIT     = 11'd1075;

endpackage
`default_nettype wire

// File: rtl/fp64_to_int32_rounding.sv
`default_nettype none
// Channel  Direction  Struct     Handshake
// in       input      f2i_in_t   in_valid / in_stall
// out      output     f2i_out_t  out_valid / out_stall
//
// One beat is accepted per cycle while in_stall is low. Each result passes
// through four register stages (decode, align, round, range check) before
// it is presented. The whole pipeline advances together; a stall at the output
// freezes every stage, so in_stall follows out_stall whenever the last stage
// holds a beat, even if earlier stages hold bubbles.
// Reset clears only the stage valid bits.
module fp64_to_int32_rounding
	import f2i_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire f2i_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output f2i_out_t      out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	// A stage may move when the last stage is empty or draining.
	assign adv      = !v_s4 || !out_stall;
	assign in_stall = !adv;

	// Stage 1: decode fields.
	logic        inv_s1, spec_s1, neg_s1;
	logic [1:0]  mode_s1;
	logic [52:0] sig_s1;
	logic [10:0] r_s1;

	// Stage 2: alignment.
	logic        inv_s2, spec_s2, neg_s2, sticky_s2, half_s2, lowz_s2;
	logic [1:0]  mode_s2;
	logic [33:0] ip_s2;

	// Stage 3: rounding.
	logic        inv_s3, spec_s3, neg_s3;
	logic [34:0] mag_s3;

	f2i_out_t res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Decode.
	logic [10:0] e_c;
	always_comb begin
		e_c = in_data.value_bits[62:52];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s1  <= in_data.round_mode[2];
			mode_s1 <= in_data.round_mode[1:0];
			neg_s1  <= in_data.value_bits[63];
			spec_s1 <= (e_c == EXP_ALL_ONES) || (e_c >= EXP_UNIT);
			sig_s1  <= {(e_c != 11'd0), in_data.value_bits[51:0]};
			r_s1    <= EXP_UNIT - ((e_c == 11'd0) ? 11'd1 : e_c);
		end
	end

	// Align: a right shift of the significand by r, keeping the integer
	// part (34 bits cover every in-range magnitude plus overflow), the
	// half bit and whether anything below it is set. Large integer parts
	// saturate so overflow is still seen.
	logic [116:0] ext_c;
	logic [116:0] sh_c;
	logic         big_c;
	always_comb begin
		ext_c = {sig_s1, 64'd0};
		big_c = (r_s1 >= 11'd64);
		sh_c  = big_c ? 117'd0 : (ext_c >> r_s1[5:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s2    <= inv_s1;
			spec_s2   <= spec_s1;
			neg_s2    <= neg_s1;
			mode_s2   <= mode_s1;
			ip_s2     <= (|sh_c[116:98]) ? {34{1'b1}} : sh_c[97:64];
			half_s2   <= sh_c[63];
			sticky_s2 <= big_c ? (|sig_s1) : (|sh_c[62:0]);
			lowz_s2   <= 1'b0;
		end
	end

	// Round.
	logic frz_c, up_c;
	always_comb begin
		frz_c = !half_s2 && !sticky_s2 && !lowz_s2;
		case ({1'b0, mode_s2})
			MODE_NEAREST: up_c = half_s2 && (sticky_s2 || ip_s2[0]);
			MODE_FLOOR:   up_c = neg_s2 && !frz_c;
			MODE_CEIL:    up_c = !neg_s2 && !frz_c;
			default:      up_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s3  <= inv_s2;
			spec_s3 <= spec_s2;
			neg_s3  <= neg_s2;
			mag_s3  <= {1'b0, ip_s2} + {34'd0, up_c};
		end
	end

	// Range check and sign.
	logic        ovf_c;
	logic [31:0] val_c;
	always_comb begin
		ovf_c = neg_s3 ? (mag_s3 > 35'h080000000) : (mag_s3 > 35'h07FFFFFFF);
		val_c = neg_s3 ? (32'd0 - mag_s3[31:0]) : mag_s3[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (inv_s3) begin
				res_s4.int_result <= -32'sd1;
				res_s4.overflow   <= 1'b0;
			end else if (spec_s3 || ovf_c) begin
				res_s4.int_result <= 32'sd0;
				res_s4.overflow   <= 1'b1;
			end else begin
				res_s4.int_result <= val_c;
				res_s4.overflow   <= 1'b0;
			end
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule
`default_nettype wire

// File: tb/tb_fp64_to_int32_rounding.sv
`default_nettype none

module tb_fp64_to_int32_rounding;
	timeunit 1ns;
	timeprecision 1ps;
	import f2i_pkg::*;

	localparam logic [2:0] MODE_TRUNC = 3'd3;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 12;

	// Scoreboard: predicts each conversion from the accepted input beat and
	// checks output beats against the oldest prediction in order.
	class conv_scoreboard;
		f2i_out_t pending[$];
		int mismatches;

		function f2i_out_t convert(f2i_in_t b);
			f2i_out_t r;
			logic neg;
			logic [10:0] ex;
			logic [52:0] sig;
			logic [63:0] ip, rem, half, mag;
			logic bump, above, tie, inexact;
			int sh;
			r.int_result = '0;
			r.overflow = 1'b0;
			if (b.round_mode > MODE_TRUNC) begin
				r.int_result = -1;
				return r;
			end
			neg = b.value_bits[63];
			ex = b.value_bits[62:52];
			sig = {1'b0, b.value_bits[51:0]};
			if (ex == EXP_ALL_ONES || ex >= EXP_UNIT) begin
				r.overflow = 1'b1;
				return r;
			end
			if (ex == 0) ex = 11'd1;
			else sig[52] = 1'b1;
			sh = int'(EXP_UNIT) - int'(ex);
			if (sh >= 64) begin
				ip = 0;
				inexact = (sig != 0);
				above = 1'b0;
				tie = 1'b0;
			end else begin
				rem = {11'd0, sig} & ((64'd1 << sh) - 64'd1);
				half = 64'd1 << (sh - 1);
				ip = {11'd0, sig} >> sh;
				inexact = (rem != 0);
				above = (rem > half);
				tie = (rem == half);
			end
			case (b.round_mode)
				MODE_NEAREST: bump = above || (tie && ip[0]);
				MODE_FLOOR:   bump = neg && inexact;
				MODE_CEIL:    bump = !neg && inexact;
				default:      bump = 1'b0;
			endcase
			mag = ip + 64'(bump);
			if (neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF)) begin
				r.overflow = 1'b1;
				return r;
			end
			r.int_result = neg ? -mag[31:0] : mag[31:0];
			return r;
		endfunction

		function void note_input(f2i_in_t b);
			pending.push_back(convert(b));
		endfunction

		function void check_result(f2i_out_t got);
			f2i_out_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: int %0d ovf %0b",
						got.int_result, got.overflow);
				return;
			end
			want = pending.pop_front();
			if (got.int_result !== want.int_result || got.overflow !== want.overflow) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected int %0d ovf %0b, got int %0d ovf %0b",
						want.int_result, want.overflow, got.int_result, got.overflow);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	f2i_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	f2i_out_t out_data;

	conv_scoreboard board = new();
	f2i_in_t directed[$];
	bit sending_done = 1'b0;
	bit long_holdoff = 1'b0;
	int cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	fp64_to_int32_rounding dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Random doubles biased toward the interesting range: exponents near the
	// int32 boundary and the rounding point, exact halves, plus raw noise.
	function automatic logic [63:0] pick_value();
		logic [63:0] v;
		int p;
		v = {$urandom, $urandom};
		p = $urandom_range(0, 99);
		if (p < 55) begin
			v[62:52] = 11'($urandom_range(1010, 1056));
		end else if (p < 70) begin
			// Small halves such as k + 0.5 land on exact ties.
			v[62:52] = 11'($urandom_range(1023, 1050));
			v[51:0] = v[51:0] & ~((52'd1 << (1075 - int'(v[62:52]) - 1)) - 52'd1);
		end else if (p < 78) begin
			v[62:52] = 11'd1054;
			if ($urandom_range(0, 1)) v[51:0] = {21'($urandom), 31'd0};
		end else if (p < 84) begin
			v[62:52] = $urandom_range(0, 1) ? 11'd0 : EXP_ALL_ONES;
		end
		return v;
	endfunction

	task automatic send_beat(input f2i_in_t b);
		in_data <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_input(b);
		@(negedge clk);
	endtask

	// Sender: directed corner cases first, then random beats with gaps.
	initial begin
		f2i_in_t b;
		int g;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_beat(directed[i]);
		for (int n = 0; n < 1050; n++) begin
			b.round_mode = 3'($urandom_range(0, 99) < 90 ? $urandom_range(0, 3)
				: $urandom_range(4, 7));
			b.value_bits = pick_value();
			send_beat(b);
			// Keep valid high across back-to-back beats; drop it only for a gap.
			g = gap_len();
			if (g > 0 && !long_holdoff) begin
				in_valid <= 1'b0;
				in_data <= {3'($urandom), $urandom, $urandom};
				repeat (g) @(negedge clk);
			end
			if (n == 300) long_holdoff = 1'b1;
		end
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Directed set: both signs of zero, ties in every mode, subnormals,
	// the int32 edges, positive infinity, NaN and every invalid mode code.
	initial begin
		logic [63:0] vals[$];
		f2i_in_t b;
		vals = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h3FF8_0000_0000_0000, 64'hC004_0000_0000_0000,
			64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
			64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF,
			64'h41DF_FFFF_FFC0_0000, 64'h41DF_FFFF_FFE0_0000,
			64'hC1E0_0000_0000_0000, 64'hC1E0_0000_0010_0000,
			64'h7FF0_0000_0000_0000, 64'hFFF8_0000_0000_0001,
			64'h4330_0000_0000_0000, 64'h432F_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF};
		foreach (vals[i]) begin
			b.value_bits = vals[i];
			b.round_mode = 3'(i % 4);
			directed.push_back(b);
		end
		for (int m = 4; m < 8; m++) begin
			b.round_mode = 3'(m);
			b.value_bits = (m == 4) ? 64'h7FF0_0000_0000_0000 : {$urandom, $urandom};
			directed.push_back(b);
		end
		b.round_mode = MODE_NEAREST;
		b.value_bits = 64'hC004_0000_0000_0000;
		directed.push_back(b);
		b.round_mode = MODE_CEIL;
		b.value_bits = 64'hC1E0_0000_0000_0000;
		directed.push_back(b);
	end

	// Receiver: random stalls, and once a long hold-off so the pipeline
	// fills and back-pressure reaches the input side.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_holdoff) begin
				out_stall <= 1'b1;
				repeat (40) @(negedge clk);
				out_stall <= 1'b0;
				long_holdoff = 1'b0;
				repeat (20) @(negedge clk);
			end else begin
				g = gap_len();
				if (g > 0) begin
					out_stall <= 1'b1;
					repeat (g) @(negedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
	end

	// Output beats are checked at the rising edge where they are accepted.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(out_data);
	end

	// Finish: drain all expected beats, allow a few more cycles for any stray
	// beat, then report. The cycle counter guards against a hang.
	initial begin
		wait (sending_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("tb_fp64_to_int32_rounding OK");
		else
			$display("tb_fp64_to_int32_rounding NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_fp64_to_int32_rounding NOT OK");
			$finish;
		end
	end

endmodule

`default_nettype wire
